[sv/assert_macros.svh]
// Assertion helpers; clocked on i_clk, quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication on the same edge.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/bctc_pkg.sv]
`timescale 1ns / 1ps
package bctc_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = VW + 1;

    typedef logic [1:0] t_op;
    localparam t_op OP_ADD   = 2'd0;
    localparam t_op OP_CHECK = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    typedef struct packed {
        logic item_done;
        logic check_start;
        logic root_step;
        logic walk_step;
        logic test_step;
        logic load_check;
    } t_cmd;

    typedef struct packed {
        logic root_end;
        logic root_new;
        logic walk_empty;
        logic test_last;
    } t_sts;

    function automatic logic [VW-1:0] lowest_set(input logic [MAX_VERTICES-1:0] vec);
        logic [VW-1:0] pos;
        pos = '0;
        for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
            if (vec[k]) begin
                pos = VW'(k);
            end
        end
        return pos;
    endfunction

endpackage

[sv/bctc_ctrl.sv]
`timescale 1ns / 1ps
module bctc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bctc_pkg::t_op   i_operation,
    output logic            o_valid,
    input  logic            i_ready,
    input  bctc_pkg::t_sts  i_sts,
    output bctc_pkg::t_cmd  o_cmd
);
    import bctc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROOT = 5'b00010,
        S_WALK = 5'b00100,
        S_TEST = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    logic   accept;

    assign slot_free = !r_out_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE) && slot_free;
    assign accept    = i_valid && o_ready;
    assign o_valid   = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_CHECK) begin
                        o_cmd.check_start = 1'b1;
                        n_state           = S_ROOT;
                    end else begin
                        o_cmd.item_done = 1'b1;
                        n_out_valid     = 1'b1;
                    end
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_sts.root_end) begin
                    n_state = S_TEST;
                end else if (i_sts.root_new) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_empty) begin
                    n_state = S_ROOT;
                end
            end
            S_TEST: begin
                o_cmd.test_step = 1'b1;
                if (i_sts.test_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_check = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[sv/bctc_dp.sv]
`timescale 1ns / 1ps
module bctc_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bctc_pkg::t_cmd           i_cmd,
    output bctc_pkg::t_sts           o_sts,
    input  logic                     i_cfg_we,
    input  logic [bctc_pkg::CW-1:0]  i_cfg_vertex_count,
    input  bctc_pkg::t_op            i_operation,
    input  logic [bctc_pkg::VW-1:0]  i_vertex_a,
    input  logic [bctc_pkg::VW-1:0]  i_vertex_b,
    output logic                     o_is_bipartite,
    output logic                     o_status
);
    import bctc_pkg::*;

    localparam int MV = MAX_VERTICES;

    logic [CW-1:0] r_count;
    logic [MV-1:0] r_adj [MV];
    logic [MV-1:0] n_adj [MV];
    logic [MV-1:0] r_colors, n_colors;
    logic [MV-1:0] r_visited, n_visited;
    logic [CW-1:0] r_depth, n_depth;
    logic [CW-1:0] r_root, n_root;
    logic [CW-1:0] r_test, n_test;
    logic          r_conflict, n_conflict;
    logic          r_out_bip, n_out_bip;
    logic          r_out_stat, n_out_stat;
    logic [VW-1:0] r_stack [MV];

    logic [CW-1:0] count_eff;
    logic [MV-1:0] inuse;
    logic [CW-1:0] depth_m1;
    logic [VW-1:0] top;
    logic [MV-1:0] open_set;
    logic [VW-1:0] next_v;
    logic [VW-1:0] root_v;
    logic [VW-1:0] test_v;
    logic [MV-1:0] same_color;
    logic          test_hit;
    logic          edge_ok;
    logic          stack_we;
    logic [VW-1:0] stack_waddr;
    logic [VW-1:0] stack_wdata;

    assign count_eff = (r_count > CW'(MV)) ? CW'(MV) : r_count;

    always_comb begin
        for (int k = 0; k < MV; k++) begin
            inuse[k] = CW'(k) < count_eff;
        end
    end

    assign depth_m1   = r_depth - CW'(1);
    assign top        = r_stack[depth_m1[VW-1:0]];
    assign open_set   = r_adj[top] & inuse & ~r_visited;
    assign next_v     = lowest_set(open_set);
    assign root_v     = r_root[VW-1:0];
    assign test_v     = r_test[VW-1:0];
    assign same_color = ~(r_colors ^ {MV{r_colors[test_v]}});
    assign test_hit   = (r_test < count_eff) && |(r_adj[test_v] & inuse & same_color);
    assign edge_ok    = ({1'b0, i_vertex_a} < count_eff) && ({1'b0, i_vertex_b} < count_eff);

    assign o_sts.root_end   = r_root >= count_eff;
    assign o_sts.root_new   = !r_visited[root_v];
    assign o_sts.walk_empty = (open_set == '0) && (r_depth == CW'(1));
    assign o_sts.test_last  = (r_test + CW'(1)) >= count_eff;

    assign o_is_bipartite = r_out_bip;
    assign o_status       = r_out_stat;

    always_comb begin
        n_adj       = r_adj;
        n_colors    = r_colors;
        n_visited   = r_visited;
        n_depth     = r_depth;
        n_root      = r_root;
        n_test      = r_test;
        n_conflict  = r_conflict;
        n_out_bip   = r_out_bip;
        n_out_stat  = r_out_stat;
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = '0;

        if (i_cmd.item_done) begin
            n_out_bip  = 1'b0;
            n_out_stat = 1'b0;
            case (i_operation)
                OP_ADD: begin
                    if (edge_ok) begin
                        n_adj[i_vertex_a][i_vertex_b] = 1'b1;
                        n_adj[i_vertex_b][i_vertex_a] = 1'b1;
                    end else begin
                        n_out_stat = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    for (int k = 0; k < MV; k++) begin
                        n_adj[k] = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.check_start) begin
            n_visited  = '0;
            n_colors   = '0;
            n_depth    = '0;
            n_root     = '0;
            n_test     = '0;
            n_conflict = 1'b0;
        end

        if (i_cmd.root_step && !o_sts.root_end) begin
            if (r_visited[root_v]) begin
                n_root = r_root + CW'(1);
            end else begin
                n_visited[root_v] = 1'b1;
                n_colors[root_v]  = 1'b0;
                n_depth           = CW'(1);
                stack_we          = 1'b1;
                stack_waddr       = '0;
                stack_wdata       = root_v;
            end
        end

        if (i_cmd.walk_step) begin
            if (open_set == '0) begin
                n_depth = depth_m1;
                if (r_depth == CW'(1)) begin
                    n_root = r_root + CW'(1);
                end
            end else begin
                n_visited[next_v] = 1'b1;
                n_colors[next_v]  = ~r_colors[top];
                if (r_depth < CW'(MV)) begin
                    stack_we    = 1'b1;
                    stack_waddr = r_depth[VW-1:0];
                    stack_wdata = next_v;
                    n_depth     = r_depth + CW'(1);
                end
            end
        end

        if (i_cmd.test_step) begin
            n_conflict = r_conflict || test_hit;
            n_test     = r_test + CW'(1);
        end

        if (i_cmd.load_check) begin
            n_out_bip  = !r_conflict;
            n_out_stat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CW'(MV);
            r_colors  <= '0;
            r_visited <= '0;
            r_depth   <= '0;
            for (int k = 0; k < MV; k++) begin
                r_adj[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_vertex_count;
            end
            r_colors  <= n_colors;
            r_visited <= n_visited;
            r_depth   <= n_depth;
            r_adj     <= n_adj;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root     <= n_root;
        r_test     <= n_test;
        r_conflict <= n_conflict;
        r_out_bip  <= n_out_bip;
        r_out_stat <= n_out_stat;
        if (stack_we) begin
            r_stack[stack_waddr] <= stack_wdata;
        end
    end

endmodule

[sv/bipartite_two_color_check_unit.sv]
// Two-color check of an undirected graph of up to 16 vertices held as an adjacency bit
// matrix. Add, clear and unused-operation requests return their response on the next
// cycle. A new request is taken only once the previous response has been taken, in the
// same cycle at the earliest.
// A check request runs a depth-first walk with an explicit stack, one stack push or pop
// per cycle, then tests one matrix row per cycle: root steps that start a walk from each
// unvisited vertex, walk steps, row tests, and a final step that loads the verdict once
// the response slot is free. The vertex count register is written on its own channel;
// the user must write it only while the unit is idle; the unit does not enforce this.
`timescale 1ns / 1ps
module bipartite_two_color_check_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [bctc_pkg::CW-1:0]  i_cfg_vertex_count,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_operation,
    input  logic [bctc_pkg::VW-1:0]  i_vertex_a,
    input  logic [bctc_pkg::VW-1:0]  i_vertex_b,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_is_bipartite,
    output logic                     o_status
);
    import bctc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bctc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bctc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_operation        (i_operation),
        .i_vertex_a         (i_vertex_a),
        .i_vertex_b         (i_vertex_b),
        .o_is_bipartite     (o_is_bipartite),
        .o_status           (o_status)
    );

endmodule

[sv/bctc_chk.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bctc_chk (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic [1:0]               i_operation,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic                     o_is_bipartite,
    input logic                     o_status
);
    import bctc_pkg::*;

    `ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_is_bipartite) && $stable(o_status), "stalled response changed")
    `ASSERT_SAME(a_no_take_on_stall, o_valid && !i_ready, !o_ready,
        "request taken over a stalled response")
    `ASSERT_NEXT(a_quick_response, i_valid && o_ready && (i_operation != OP_CHECK),
        o_valid, "non-check response missing")
    `ASSERT_SAME(a_status_excl, o_valid && o_status, !o_is_bipartite,
        "status and verdict both set")

endmodule

bind bipartite_two_color_check_unit bctc_chk u_chk (.*);
